FILE: rtl/core/itp_pkg.sv
// Shared types and constants for the integer text parser.
package itp_pkg;

    localparam int VALUE_BITS_DEFAULT = 32;
    localparam int QUEUE_DEPTH = 2;
    localparam int CHAR_BITS = 8;
    localparam int WIDTH_BITS = 8;

    // Configuration register indexes
    localparam logic CFG_BASE_MODE = 1'b0;
    localparam logic CFG_MAX_WIDTH = 1'b1;

    // Base codes
    localparam logic [1:0] BASE_AUTO = 2'd0;
    localparam logic [1:0] BASE_OCT  = 2'd1;
    localparam logic [1:0] BASE_DEC  = 2'd2;
    localparam logic [1:0] BASE_HEX  = 2'd3;

    localparam logic [1:0] BASE_MODE_RESET = BASE_DEC;
    localparam logic [WIDTH_BITS-1:0] MAX_WIDTH_RESET = '0;

    // Characters
    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_LA    = 8'h61;
    localparam logic [7:0] CH_LF    = 8'h66;
    localparam logic [7:0] CH_UA    = 8'h41;
    localparam logic [7:0] CH_UF    = 8'h46;
    localparam logic [7:0] CH_LX    = 8'h78;
    localparam logic [7:0] CH_UX    = 8'h58;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_PLUS  = 8'h2b;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_CR    = 8'h0d;

    // Classified character, as queued between front and back
    typedef struct packed {
        logic       eoi;
        logic       space;
        logic       sign;
        logic       minus;
        logic       zero;
        logic       ex;
        logic       dig_ok;
        logic [3:0] dig;
    } cls_t;

endpackage

FILE: rtl/core/itp_front.sv
// Front end: accepts characters and classifies them for the back end.
module itp_front
    import itp_pkg::*;
(
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [CHAR_BITS-1:0] s_tdata,   // [7:0] char_code
    input  logic                 s_tlast,   // end_of_input
    input  logic                 queue_full,
    output logic                 push,
    output cls_t                 entry
);

    logic [7:0] c;

    assign c        = s_tdata;
    assign s_tready = !queue_full;
    assign push     = s_tvalid && !queue_full;

    always_comb
    begin
        entry        = '0;
        entry.eoi    = s_tlast;
        entry.space  = (c == CH_SPACE) || ((c >= CH_TAB) && (c <= CH_CR));
        entry.sign   = (c == CH_MINUS) || (c == CH_PLUS);
        entry.minus  = (c == CH_MINUS);
        entry.zero   = (c == CH_ZERO);
        entry.ex     = (c == CH_LX) || (c == CH_UX);
        if ((c >= CH_ZERO) && (c <= CH_NINE))
        begin
            entry.dig_ok = 1'b1;
            entry.dig    = 4'(c - CH_ZERO);
        end
        else if ((c >= CH_LA) && (c <= CH_LF))
        begin
            entry.dig_ok = 1'b1;
            entry.dig    = 4'(c - CH_LA + 8'd10);
        end
        else if ((c >= CH_UA) && (c <= CH_UF))
        begin
            entry.dig_ok = 1'b1;
            entry.dig    = 4'(c - CH_UA + 8'd10);
        end
    end

endmodule

FILE: rtl/core/itp_queue.sv
// Short FIFO of classified characters between front and back.
module itp_queue
    import itp_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cls_t push_data,
    output logic full,
    input  logic pop,
    output logic not_empty,
    output cls_t pop_data
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);
    localparam logic [PTR_BITS-1:0] LAST = PTR_BITS'(QUEUE_DEPTH - 1);

    cls_t mem [QUEUE_DEPTH];
    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;

    assign full      = (count_reg == CNT_BITS'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_data  = mem[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + 1'b1;
        if (pop)
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + 1'b1;
        if (push && !pop)
            count_next = count_reg + 1'b1;
        else if (pop && !push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[wr_ptr_reg] <= push_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

FILE: rtl/core/itp_back.sv
// Back end: field state machine, accumulator and result register.
module itp_back
    import itp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic [1:0]            base_mode,
    input  logic [WIDTH_BITS-1:0] max_width,
    input  logic                  q_valid,
    input  cls_t                  q_data,
    output logic                  pop,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [VALUE_BITS-1:0] out_value,
    output logic                  out_status,
    output logic                  out_consumed
);

    localparam logic [1:0] PH_SKIP   = 2'd0;
    localparam logic [1:0] PH_LEAD   = 2'd1;
    localparam logic [1:0] PH_ZERO   = 2'd2;
    localparam logic [1:0] PH_DIGITS = 2'd3;

    logic [1:0]            phase_reg, phase_next;
    logic [VALUE_BITS-1:0] acc_reg, acc_next;
    logic                  neg_reg, neg_next;
    logic [1:0]            abase_reg, abase_next;
    logic [WIDTH_BITS-1:0] cnt_reg, cnt_next;
    logic                  have_reg, have_next;

    logic                  valid_reg, valid_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic                  status_reg, status_next;
    logic                  consumed_reg, consumed_next;

    logic                  emit, cons;
    logic                  take_digit;
    logic [1:0]            dbase;
    logic                  lead_path;
    logic [VALUE_BITS-1:0] res_value;
    logic                  have_pre;

    function automatic logic digit_fits(input logic [3:0] d, input logic [1:0] b);
        logic ok;
        begin
            case (b)
                BASE_OCT: ok = !d[3];
                BASE_HEX: ok = 1'b1;
                default:  ok = (d < 4'd10);
            endcase
            return ok;
        end
    endfunction

    function automatic logic [WIDTH_BITS-1:0] bump(input logic [WIDTH_BITS-1:0] n);
        return (n == '1) ? n : n + 1'b1;
    endfunction

    assign pop = q_valid && (!valid_reg || m_tready);

    always_comb
    begin
        phase_next = phase_reg;
        acc_next   = acc_reg;
        neg_next   = neg_reg;
        abase_next = abase_reg;
        cnt_next   = cnt_reg;
        have_next  = have_reg;
        emit       = 1'b0;
        cons       = 1'b0;
        take_digit = 1'b0;
        lead_path  = 1'b0;
        dbase      = abase_reg;

        if (q_data.eoi)
            emit = 1'b1;
        else
        begin
            case (phase_reg)
                PH_SKIP:
                begin
                    if (q_data.space)
                    begin
                        // whitespace before the field is dropped
                    end
                    else if (q_data.sign)
                    begin
                        neg_next   = q_data.minus;
                        phase_next = PH_LEAD;
                        cnt_next   = bump(cnt_reg);
                        cons       = 1'b1;
                    end
                    else
                        lead_path = 1'b1;
                end
                PH_LEAD:
                    lead_path = 1'b1;
                PH_ZERO:
                begin
                    if (q_data.ex)
                    begin
                        abase_next = BASE_HEX;
                        phase_next = PH_DIGITS;
                        cnt_next   = bump(cnt_reg);
                        cons       = 1'b1;
                    end
                    else
                    begin
                        dbase      = (abase_reg == BASE_AUTO) ? BASE_OCT : abase_reg;
                        take_digit = 1'b1;
                    end
                end
                default:
                    take_digit = 1'b1;
            endcase

            if (lead_path)
            begin
                if (q_data.zero && ((base_mode == BASE_AUTO) || (base_mode == BASE_HEX)))
                begin
                    abase_next = base_mode;
                    have_next  = 1'b1;
                    acc_next   = '0;
                    phase_next = PH_ZERO;
                    cnt_next   = bump(cnt_reg);
                    cons       = 1'b1;
                end
                else
                begin
                    dbase      = (base_mode == BASE_AUTO) ? BASE_DEC : base_mode;
                    take_digit = 1'b1;
                end
            end

            if (take_digit)
            begin
                abase_next = dbase;
                if (!q_data.dig_ok || !digit_fits(q_data.dig, dbase))
                    emit = 1'b1;
                else
                begin
                    case (dbase)
                        BASE_OCT: acc_next = (acc_reg << 3) + VALUE_BITS'(q_data.dig);
                        BASE_HEX: acc_next = (acc_reg << 4) + VALUE_BITS'(q_data.dig);
                        default:  acc_next = (acc_reg << 3) + (acc_reg << 1)
                                             + VALUE_BITS'(q_data.dig);
                    endcase
                    have_next  = 1'b1;
                    phase_next = PH_DIGITS;
                    cnt_next   = bump(cnt_reg);
                    cons       = 1'b1;
                end
            end

            // width reached by a consumed character
            if (cons && (max_width != '0) && (cnt_next >= max_width))
                emit = 1'b1;
        end

        // have flag as seen by the result, before the field is cleared
        have_pre = have_next;

        if (!have_next)
            res_value = '0;
        else if (neg_next)
            res_value = '0 - acc_next;
        else
            res_value = acc_next;

        if (emit)
        begin
            phase_next = PH_SKIP;
            acc_next   = '0;
            neg_next   = 1'b0;
            abase_next = BASE_AUTO;
            cnt_next   = '0;
            have_next  = 1'b0;
        end
    end

    always_comb
    begin
        valid_next    = valid_reg;
        value_next    = value_reg;
        status_next   = status_reg;
        consumed_next = consumed_reg;
        if (m_tready)
            valid_next = 1'b0;
        if (pop && emit)
        begin
            valid_next    = 1'b1;
            value_next    = res_value;
            status_next   = !have_pre;
            consumed_next = cons;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg    <= value_next;
        status_reg   <= status_next;
        consumed_reg <= consumed_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SKIP;
            acc_reg   <= '0;
            neg_reg   <= 1'b0;
            abase_reg <= BASE_AUTO;
            cnt_reg   <= '0;
            have_reg  <= 1'b0;
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            if (pop)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                neg_reg   <= neg_next;
                abase_reg <= abase_next;
                cnt_reg   <= cnt_next;
                have_reg  <= have_next;
            end
        end
    end

    assign m_tvalid     = valid_reg;
    assign out_value    = value_reg;
    assign out_status   = status_reg;
    assign out_consumed = consumed_reg;

endmodule

FILE: rtl/core/integer_text_parser.sv
// Top level of the streaming signed integer text parser.
//
// Parses one signed integer field at a time from a byte stream, in the manner
// of strtol or scanf %i/%o/%d/%x. Leading whitespace is skipped, an optional
// sign and (hex/auto) a 0x/0X prefix are taken, and digits accumulate modulo
// 2^VALUE_BITS. A field ends on the first invalid character (pushed back:
// item_consumed = 0, present it again), on s_tlast (end of input, never
// consumed), or when max_width field characters have been taken (that
// character is consumed). One result transfer per finished field; whitespace
// and in-field characters produce none. Throughput is one character per
// cycle while the output is not stalled: the front end classifies the byte
// in the cycle it is accepted, a two-entry queue decouples it from the back
// end, and the back end retires one queued character per cycle with a
// single shift-and-add on the accumulator (x8, x10 or x16). The character
// ending a field passes the queue, then m_tvalid rises. The result sits in an
// output register; while it waits for m_tready the back end holds, the queue
// takes up to two more characters and then s_tready drops. base_mode
// (index 0; 0 auto, 1 octal, 2 decimal, 3 hex; reset decimal) and max_width
// (index 1; 0 = unlimited; reset 0) are written through cfg_we while idle.
module integer_text_parser
    import itp_pkg::*;
#(
    parameter int VALUE_BITS = VALUE_BITS_DEFAULT
)
(
    input  logic                        clk,
    input  logic                        rst_n,
    // configuration
    input  logic                        cfg_we,
    input  logic                        cfg_index,
    input  logic [WIDTH_BITS-1:0]       cfg_data,
    // character stream
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [CHAR_BITS-1:0]        s_tdata,  // [7:0] char_code
    input  logic                        s_tlast,  // end_of_input
    // result stream
    output logic                        m_tvalid,
    input  logic                        m_tready,
    // value, status, item_consumed from bit 0 up, zero padded to bytes
    output logic [((VALUE_BITS + 9) / 8) * 8 - 1:0] m_tdata
);

    localparam int OUT_BYTES = (VALUE_BITS + 2 + 7) / 8;
    localparam int PAD_BITS  = OUT_BYTES * 8 - VALUE_BITS - 2;

    logic [1:0]            base_mode_reg;
    logic [WIDTH_BITS-1:0] max_width_reg;

    logic                  queue_full;
    logic                  push;
    cls_t                  entry;
    logic                  q_valid;
    logic                  pop;
    cls_t                  q_data;

    logic [VALUE_BITS-1:0] out_value;
    logic                  out_status;
    logic                  out_consumed;

    // configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_mode_reg <= BASE_MODE_RESET;
            max_width_reg <= MAX_WIDTH_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_BASE_MODE: base_mode_reg <= cfg_data[1:0];
                CFG_MAX_WIDTH: max_width_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    itp_front u_front (
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .s_tlast    (s_tlast),
        .queue_full (queue_full),
        .push       (push),
        .entry      (entry)
    );

    itp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_data (entry),
        .full      (queue_full),
        .pop       (pop),
        .not_empty (q_valid),
        .pop_data  (q_data)
    );

    itp_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .base_mode    (base_mode_reg),
        .max_width    (max_width_reg),
        .q_valid      (q_valid),
        .q_data       (q_data),
        .pop          (pop),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .out_value    (out_value),
        .out_status   (out_status),
        .out_consumed (out_consumed)
    );

    generate
        if (PAD_BITS > 0)
        begin : g_pad
            assign m_tdata = {{PAD_BITS{1'b0}}, out_consumed, out_status, out_value};
        end
        else
        begin : g_nopad
            assign m_tdata = {out_consumed, out_status, out_value};
        end
    endgenerate

endmodule

FILE: tb/sv/integer_text_parser_test.sv
// Self-checking testbench for the streaming integer text parser.
module integer_text_parser_test;
    import itp_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HOLD_OFF_CYCLES = 300;
    localparam int STALL_LIMIT     = 3000;
    localparam int SETTLE_CYCLES   = 10;

    // Parser phases as the predictor sees them
    typedef enum logic [1:0] {
        PH_SKIP,
        PH_SIGNED,
        PH_LEAD_ZERO,
        PH_DIGITS
    } phase_t;

    typedef struct {
        logic [31:0] value;
        bit          status;
        bit          consumed;
    } field_result_t;

    logic        clk       = 1'b0;
    logic        rst_n     = 1'b0;
    logic        cfg_we    = 1'b0;
    logic        cfg_index = CFG_BASE_MODE;
    logic [7:0]  cfg_data  = '0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata   = '0;   // [7:0] char_code
    logic        s_tlast   = 1'b0; // end_of_input
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [39:0] m_tdata;          // [31:0] value, [32] status, [33] item_consumed

    integer_text_parser u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Predictor: mirrors the parser state and queues the field results
    // ------------------------------------------------------------------
    logic [1:0]    base_sel  = BASE_MODE_RESET;
    logic [7:0]    width_cap = MAX_WIDTH_RESET;
    phase_t        phase     = PH_SKIP;
    logic [31:0]   acc       = '0;
    bit            neg       = 1'b0;
    logic [1:0]    field_base = BASE_AUTO;
    logic [7:0]    field_chars = '0;
    bit            got_digit = 1'b0;
    bit            pushed_back;
    field_result_t expected_fields[$];

    int err_count    = 0;
    int chars_sent   = 0;
    int burst_left   = 0;
    int hold_requests = 0;

    function automatic void close_field(bit consumed);
        field_result_t r;
        r.value    = !got_digit ? 32'd0 : (neg ? 32'd0 - acc : acc);
        r.status   = !got_digit;
        r.consumed = consumed;
        expected_fields.push_back(r);
        pushed_back = !consumed;
        phase       = PH_SKIP;
        acc         = '0;
        neg         = 1'b0;
        field_base  = BASE_AUTO;
        field_chars = '0;
        got_digit   = 1'b0;
    endfunction

    // Count a field character; close the field if the width is now used up
    function automatic void count_and_check();
        if (field_chars != 8'd255)
            field_chars++;
        if (width_cap != 0 && field_chars >= width_cap)
            close_field(1'b1);
    endfunction

    function automatic int unsigned digit_of(logic [7:0] c);
        if (c >= CH_ZERO && c <= CH_NINE) return c - CH_ZERO;
        if (c >= CH_LA && c <= CH_LF) return c - CH_LA + 10;
        if (c >= CH_UA && c <= CH_UF) return c - CH_UA + 10;
        return 99;
    endfunction

    function automatic void take_digit(logic [7:0] c);
        int unsigned radix;
        int unsigned d;
        radix = (field_base == BASE_OCT) ? 8 : (field_base == BASE_HEX) ? 16 : 10;
        d = digit_of(c);
        if (d >= radix)
        begin
            close_field(1'b0);
            return;
        end
        acc       = acc * radix + d;
        got_digit = 1'b1;
        phase     = PH_DIGITS;
        count_and_check();
    endfunction

    function automatic void take_lead(logic [7:0] c);
        if (c == CH_ZERO && (base_sel == BASE_AUTO || base_sel == BASE_HEX))
        begin
            // a leading zero is already a digit; it may still turn into 0x
            field_base = base_sel;
            got_digit  = 1'b1;
            acc        = '0;
            phase      = PH_LEAD_ZERO;
            count_and_check();
        end
        else
        begin
            field_base = (base_sel == BASE_AUTO) ? BASE_DEC : base_sel;
            take_digit(c);
        end
    endfunction

    // Advance the model by one accepted character; returns 1 on push-back
    function automatic bit parse_char(logic [7:0] c, bit eoi);
        pushed_back = 1'b0;
        if (eoi)
        begin
            close_field(1'b0);
            return 1'b0;
        end
        case (phase)
            PH_SKIP:
                if (c == CH_SPACE || (c >= CH_TAB && c <= CH_CR))
                    ;
                else if (c == CH_MINUS || c == CH_PLUS)
                begin
                    neg   = (c == CH_MINUS);
                    phase = PH_SIGNED;
                    count_and_check();
                end
                else
                    take_lead(c);
            PH_SIGNED:
                take_lead(c);
            PH_LEAD_ZERO:
                if (c == CH_LX || c == CH_UX)
                begin
                    field_base = BASE_HEX;
                    phase      = PH_DIGITS;
                    count_and_check();
                end
                else
                begin
                    if (field_base == BASE_AUTO)
                        field_base = BASE_OCT;
                    take_digit(c);
                end
            default:
                take_digit(c);
        endcase
        return pushed_back;
    endfunction

    // ------------------------------------------------------------------
    // Result side: stall pattern, long hold-off on request, checking
    // ------------------------------------------------------------------
    int hold_seen  = 0;
    int hold_left  = 0;
    int ready_left = 0;
    int stall_left = 0;

    always @(negedge clk)
    begin
        if (hold_seen != hold_requests)
        begin
            hold_seen = hold_requests;
            hold_left = HOLD_OFF_CYCLES;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (ready_left > 0)
        begin
            ready_left--;
            m_tready <= 1'b1;
        end
        else if (stall_left > 0)
        begin
            stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            ready_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 60 : 12);
            stall_left = $urandom_range(0, 5);
            m_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        field_result_t exp_r;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_fields.size() == 0)
            begin
                $error("unexpected result transfer: m_tdata=%h", m_tdata);
                err_count++;
            end
            else
            begin
                exp_r = expected_fields.pop_front();
                if (m_tdata[31:0] !== exp_r.value)
                begin
                    $error("value: expected %0d, actual %0d",
                           $signed(exp_r.value), $signed(m_tdata[31:0]));
                    err_count++;
                end
                if (m_tdata[32] !== exp_r.status)
                begin
                    $error("status: expected %0d, actual %0d", exp_r.status, m_tdata[32]);
                    err_count++;
                end
                if (m_tdata[33] !== exp_r.consumed)
                begin
                    $error("item_consumed: expected %0d, actual %0d",
                           exp_r.consumed, m_tdata[33]);
                    err_count++;
                end
            end
        end
    end

    // Watchdog: ends the run if no transfer happens on either side for too long
    int quiet_cycles = 0;

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= STALL_LIMIT)
        begin
            $display("integer_text_parser_test: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Character side
    // ------------------------------------------------------------------

    // One character transfer, in bursts with random gaps between them
    task automatic send_char(input logic [7:0] c, input bit eoi, output bit pushed);
        @(negedge clk);
        if (burst_left == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(negedge clk);
            burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 20);
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= eoi;
        do
            @(posedge clk);
        while (!s_tready);
        chars_sent++;
        pushed = parse_char(c, eoi);
    endtask

    task automatic send_text(input string txt);
        bit p;
        for (int i = 0; i < txt.len(); i++)
            send_char(txt[i], 1'b0, p);
    endtask

    task automatic send_eoi();
        bit p;
        send_char(8'($urandom_range(0, 255)), 1'b1, p);
    endtask

    // Stop offering characters and wait until every field result has arrived
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (expected_fields.size() != 0)
            @(posedge clk);
        // whitespace produces no result, so give the pipeline time to empty
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic idx, input logic [7:0] data);
        drain();
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge clk);
        cfg_we <= 1'b0;
        if (idx == CFG_BASE_MODE)
            base_sel = data[1:0];
        else
            width_cap = data;
    endtask

    function automatic logic [7:0] space_char();
        int unsigned k;
        k = $urandom_range(0, 5);
        return (k == 0) ? CH_SPACE : 8'(CH_TAB + k - 1);
    endfunction

    function automatic logic [7:0] digit_char(logic [1:0] b);
        int unsigned d;
        d = $urandom_range(0, (b == BASE_OCT) ? 7 : (b == BASE_HEX) ? 15 : 9);
        if (d < 10)
            return 8'(CH_ZERO + d);
        return 8'(($urandom_range(0, 1) ? CH_LA : CH_UA) + d - 10);
    endfunction

    // A well-formed field with random content, or now and then plain noise
    task automatic send_field();
        bit p;
        logic [1:0] digit_base;
        int n_digits;
        int tail;
        logic [7:0] c;
        if ($urandom_range(0, 99) < 15)
        begin
            repeat ($urandom_range(1, 4))
                send_char(8'($urandom_range(0, 255)), $urandom_range(0, 9) == 0, p);
            return;
        end
        repeat ($urandom_range(0, 2)) send_char(space_char(), 1'b0, p);
        case ($urandom_range(0, 3))
            0: send_char(CH_MINUS, 1'b0, p);
            1: send_char(CH_PLUS, 1'b0, p);
            default: ;
        endcase
        digit_base = (base_sel == BASE_AUTO) ? BASE_DEC : base_sel;
        if ((base_sel == BASE_AUTO || base_sel == BASE_HEX) && $urandom_range(0, 9) < 4)
        begin
            send_char(CH_ZERO, 1'b0, p);
            if (base_sel == BASE_HEX || $urandom_range(0, 1))
            begin
                send_char($urandom_range(0, 1) ? CH_LX : CH_UX, 1'b0, p);
                digit_base = BASE_HEX;
            end
            else
                digit_base = BASE_OCT;
        end
        // mostly short numbers; a few long enough to wrap
        n_digits = ($urandom_range(0, 7) == 0) ? $urandom_range(11, 16) : $urandom_range(1, 10);
        repeat (n_digits) send_char(digit_char(digit_base), 1'b0, p);
        tail = $urandom_range(0, 3);
        if (tail == 3)
            send_eoi();
        else
        begin
            c = (tail == 0) ? space_char() : 8'($urandom_range(0, 255));
            send_char(c, 1'b0, p);
            // a pushed-back character is presented again, as a caller would
            if (p && $urandom_range(0, 1))
                send_char(c, 1'b0, p);
        end
    endtask

    task automatic send_fields(input int n_chars);
        int stop_at;
        stop_at = chars_sent + n_chars;
        while (chars_sent < stop_at)
            send_field();
        send_eoi();
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Decimal default: whitespace, signs, a second sign, extreme byte, end of input
    task automatic test_decimal_basics();
        bit p;
        send_text(" \t\r-99");
        send_char(8'hFF, 1'b0, p);
        send_char(8'hFF, 1'b0, p);
        send_text("+--7");
        send_char(8'h00, 1'b1, p);
        send_eoi();
    endtask

    // Auto mode: 0x followed by a non-hex digit, and octal from a leading zero
    task automatic test_auto_prefix();
        write_reg(CFG_BASE_MODE, 8'(BASE_AUTO));
        send_text("0xg017 ");
        send_eoi();
    endtask

    // Width limit reached on a digit, on a lone sign and on a lead zero
    task automatic test_width_limit();
        write_reg(CFG_BASE_MODE, 8'(BASE_HEX));
        write_reg(CFG_MAX_WIDTH, 8'd3);
        send_text("-Ff");
        write_reg(CFG_MAX_WIDTH, 8'd1);
        send_text("+0");
    endtask

    // Random fields across several base and width settings
    task automatic test_random_fields();
        logic [1:0] bases [8]  = '{BASE_DEC, BASE_AUTO, BASE_OCT, BASE_HEX,
                                   BASE_HEX, BASE_AUTO, BASE_DEC, BASE_AUTO};
        logic [7:0] widths [8] = '{8'd0, 8'd0, 8'd3, 8'd255, 8'd0, 8'd1, 8'd8, 8'd200};
        for (int i = 0; i < 8; i++)
        begin
            write_reg(CFG_BASE_MODE, 8'(bases[i]));
            write_reg(CFG_MAX_WIDTH, widths[i]);
            send_fields(70);
        end
    endtask

    // Result side held off for a long stretch so the input stalls
    task automatic test_backpressure();
        write_reg(CFG_BASE_MODE, 8'(BASE_AUTO));
        write_reg(CFG_MAX_WIDTH, 8'd0);
        hold_requests++;
        send_fields(80);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_decimal_basics();
        test_auto_prefix();
        test_width_limit();
        test_random_fields();
        test_backpressure();

        drain();
        if (err_count == 0)
            $display("integer_text_parser_test: done, clean");
        else
            $display("integer_text_parser_test: done, errors");
        $finish;
    end

endmodule
